// File: src/rpfa_pkg.sv
package rpfa_pkg;

    localparam int MAX_PAGES  = 32768;
    localparam int PAGE_SHIFT = 12;
    localparam int COUNT_BITS = 16;

    localparam int ADDR_W    = 40;
    localparam int FIELD_W   = 16;
    localparam int CFG_IDX_W = 2;
    localparam int PAGE_W    = $clog2(MAX_PAGES);
    localparam int PCNT_W    = $clog2(MAX_PAGES + 1);
    localparam int NUM_W     = ADDR_W - PAGE_SHIFT;

    typedef enum logic [1:0] {
        KIND_ALLOC = 2'd0,
        KIND_FREE  = 2'd1,
        KIND_SHARE = 2'd2,
        KIND_INIT  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_ADDR  = 3'd1,
        ST_DBL_FREE  = 3'd2,
        ST_OOM       = 3'd3,
        ST_SHARE_FREE = 3'd4,
        ST_SATURATED = 3'd5
    } t_status;

    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_BASE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RESERVED  = 2'd2;

    typedef struct packed {
        logic              in_range;
        logic              aligned;
        logic [PAGE_W-1:0] page;
    } t_addr_chk;

endpackage

// File: src/rpfa_ram.sv
module rpfa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/rpfa_addr_chk.sv
module rpfa_addr_chk (
    input  logic [rpfa_pkg::ADDR_W-1:0] i_addr,
    input  logic [rpfa_pkg::ADDR_W-1:0] i_base,
    input  logic [rpfa_pkg::PCNT_W-1:0] i_managed,
    output rpfa_pkg::t_addr_chk         o_chk
);

    logic [rpfa_pkg::ADDR_W-1:0] diff;
    logic [rpfa_pkg::NUM_W-1:0]  num;

    always_comb begin
        diff = i_addr - i_base;
        num  = diff[rpfa_pkg::ADDR_W-1:rpfa_pkg::PAGE_SHIFT];
        o_chk.in_range = (i_addr >= i_base) && (64'(num) < 64'(i_managed));
        o_chk.aligned  = (i_addr[rpfa_pkg::PAGE_SHIFT-1:0] == '0);
        o_chk.page     = rpfa_pkg::PAGE_W'(num);
    end

endmodule

// File: src/refcounted_page_frame_allocator.sv
// Page frame allocator: a LIFO stack of free page numbers and a reference count
// per page, each held in a single-port-write synchronous RAM. The accept
// cycle of a request checks the address and reads both RAMs; the exec state
// then writes back and loads the result register once the output is free,
// and no new word is taken until that write-back is done. An init request
// sweeps every page index, one a cycle, writing its count and, for an
// unreserved managed page, a stack entry. After reset the block runs the same
// sweep to clear the counts and holds o_in_stall high while it runs;
// configuration writes are taken throughout.
module refcounted_page_frame_allocator (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [rpfa_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [rpfa_pkg::ADDR_W-1:0]    i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [1:0]                     i_kind,
    input  logic [rpfa_pkg::ADDR_W-1:0]    i_page_addr,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [2:0]                     o_status,
    output logic [rpfa_pkg::ADDR_W-1:0]    o_granted_addr,
    output logic [rpfa_pkg::FIELD_W-1:0]   o_count_after,
    output logic [rpfa_pkg::FIELD_W-1:0]   o_free_total,
    output logic [rpfa_pkg::FIELD_W-1:0]   o_used_total
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SWEEP
    } t_state;

    t_state r_state;

    logic [rpfa_pkg::ADDR_W-1:0]  r_page_base;
    logic [rpfa_pkg::FIELD_W-1:0] r_total;
    logic [rpfa_pkg::FIELD_W-1:0] r_resv;

    logic [rpfa_pkg::PCNT_W-1:0] r_free_cnt, n_free_cnt;
    logic [rpfa_pkg::PCNT_W-1:0] r_used_cnt, n_used_cnt;
    logic [rpfa_pkg::PCNT_W-1:0] r_lim_r, r_lim_t;
    logic [rpfa_pkg::PAGE_W-1:0] r_idx;
    logic                        r_init;

    rpfa_pkg::t_kind     r_kind;
    rpfa_pkg::t_addr_chk r_chk;
    rpfa_pkg::t_addr_chk chk;

    logic                          r_out_valid;
    rpfa_pkg::t_status             r_status, n_status;
    logic [rpfa_pkg::ADDR_W-1:0]   r_granted, n_granted;
    logic [rpfa_pkg::FIELD_W-1:0]  r_count, n_count;
    logic [rpfa_pkg::FIELD_W-1:0]  r_free_out, r_used_out;

    logic [rpfa_pkg::PCNT_W-1:0] managed, resv_eff, idx_ext;
    logic                        accept, out_free, fire, sweep_last;

    logic                            rc_we;
    logic [rpfa_pkg::PAGE_W-1:0]     rc_wa, rc_ra;
    logic [rpfa_pkg::COUNT_BITS-1:0] rc_wd, rc_rd, rc_dec;
    logic                            sk_we;
    logic [rpfa_pkg::PAGE_W-1:0]     sk_wa, sk_wd, sk_ra, sk_rd;

    always_comb begin
        if ({16'd0, r_total} < 32'(rpfa_pkg::MAX_PAGES)) begin
            managed = rpfa_pkg::PCNT_W'(r_total);
        end else begin
            managed = rpfa_pkg::PCNT_W'(rpfa_pkg::MAX_PAGES);
        end
        if (32'(r_resv) < 32'(managed)) begin
            resv_eff = rpfa_pkg::PCNT_W'(r_resv);
        end else begin
            resv_eff = managed;
        end
    end

    rpfa_addr_chk u_chk (
        .i_addr    (i_page_addr),
        .i_base    (r_page_base),
        .i_managed (managed),
        .o_chk     (chk)
    );

    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign fire       = (r_state == S_EXEC) && out_free;
    assign idx_ext    = rpfa_pkg::PCNT_W'(r_idx);
    assign sweep_last = (r_idx == rpfa_pkg::PAGE_W'(rpfa_pkg::MAX_PAGES - 1));

    // read address held in exec so the registered data stays put during a stall
    assign rc_ra  = (r_state == S_IDLE) ? chk.page : r_chk.page;
    assign sk_ra  = rpfa_pkg::PAGE_W'(r_free_cnt - 1'b1);
    assign rc_dec = rc_rd - 1'b1;

    rpfa_ram #(
        .WIDTH (rpfa_pkg::COUNT_BITS),
        .DEPTH (rpfa_pkg::MAX_PAGES)
    ) u_refcount (
        .i_clk   (i_clk),
        .i_we    (rc_we),
        .i_waddr (rc_wa),
        .i_wdata (rc_wd),
        .i_raddr (rc_ra),
        .o_rdata (rc_rd)
    );

    rpfa_ram #(
        .WIDTH (rpfa_pkg::PAGE_W),
        .DEPTH (rpfa_pkg::MAX_PAGES)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (sk_we),
        .i_waddr (sk_wa),
        .i_wdata (sk_wd),
        .i_raddr (sk_ra),
        .o_rdata (sk_rd)
    );

    always_comb begin
        rc_we      = 1'b0;
        rc_wa      = r_chk.page;
        rc_wd      = '0;
        sk_we      = 1'b0;
        sk_wa      = rpfa_pkg::PAGE_W'(r_free_cnt);
        sk_wd      = r_chk.page;
        n_free_cnt = r_free_cnt;
        n_used_cnt = r_used_cnt;
        n_status   = rpfa_pkg::ST_OK;
        n_granted  = '0;
        n_count    = '0;
        if (r_state == S_SWEEP) begin
            rc_we = 1'b1;
            rc_wa = r_idx;
            rc_wd = (idx_ext < r_lim_r) ? rpfa_pkg::COUNT_BITS'(1) : '0;
            sk_we = (idx_ext >= r_lim_r) && (idx_ext < r_lim_t);
            sk_wa = rpfa_pkg::PAGE_W'(idx_ext - r_lim_r);
            sk_wd = r_idx;
        end else if (fire) begin
            case (r_kind)
                rpfa_pkg::KIND_ALLOC: begin
                    if (r_free_cnt == '0) begin
                        n_status = rpfa_pkg::ST_OOM;
                    end else begin
                        n_free_cnt = r_free_cnt - 1'b1;
                        n_used_cnt = r_used_cnt + 1'b1;
                        rc_we      = 1'b1;
                        rc_wa      = sk_rd;
                        rc_wd      = rpfa_pkg::COUNT_BITS'(1);
                        n_granted  = r_page_base
                                   + (rpfa_pkg::ADDR_W'(sk_rd) << rpfa_pkg::PAGE_SHIFT);
                        n_count    = rpfa_pkg::FIELD_W'(1);
                    end
                end
                rpfa_pkg::KIND_FREE: begin
                    if (!r_chk.aligned || !r_chk.in_range) begin
                        n_status = rpfa_pkg::ST_BAD_ADDR;
                    end else if (rc_rd == '0) begin
                        n_status = rpfa_pkg::ST_DBL_FREE;
                    end else begin
                        rc_we   = 1'b1;
                        rc_wd   = rc_dec;
                        n_count = rpfa_pkg::FIELD_W'(rc_dec);
                        if (rc_dec == '0) begin
                            // last reference gone: page goes back on the stack
                            if (r_free_cnt != rpfa_pkg::PCNT_W'(rpfa_pkg::MAX_PAGES)) begin
                                sk_we      = 1'b1;
                                n_free_cnt = r_free_cnt + 1'b1;
                            end
                            if (r_used_cnt != '0) begin
                                n_used_cnt = r_used_cnt - 1'b1;
                            end
                        end
                    end
                end
                rpfa_pkg::KIND_SHARE: begin
                    if (!r_chk.in_range) begin
                        n_status = rpfa_pkg::ST_BAD_ADDR;
                    end else if (rc_rd == '0) begin
                        n_status = rpfa_pkg::ST_SHARE_FREE;
                    end else if (rc_rd == '1) begin
                        n_status = rpfa_pkg::ST_SATURATED;
                        n_count  = rpfa_pkg::FIELD_W'(rc_rd);
                    end else begin
                        rc_we   = 1'b1;
                        rc_wd   = rc_rd + 1'b1;
                        n_count = rpfa_pkg::FIELD_W'(rc_rd + 1'b1);
                    end
                end
                default: begin
                    // init: counters were set when the sweep began
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_SWEEP;
            r_idx       <= '0;
            r_init      <= 1'b0;
            r_lim_r     <= '0;
            r_lim_t     <= '0;
            r_free_cnt  <= '0;
            r_used_cnt  <= '0;
            r_out_valid <= 1'b0;
            r_page_base <= '0;
            r_total     <= rpfa_pkg::FIELD_W'(32768);
            r_resv      <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    rpfa_pkg::CFG_PAGE_BASE: r_page_base <= i_cfg_data;
                    rpfa_pkg::CFG_TOTAL:     r_total <= i_cfg_data[rpfa_pkg::FIELD_W-1:0];
                    rpfa_pkg::CFG_RESERVED:  r_resv <= i_cfg_data[rpfa_pkg::FIELD_W-1:0];
                    default: begin
                    end
                endcase
            end

            // a result taken while the next one loads keeps the valid flag up
            if (r_out_valid && !i_out_stall && !fire) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_kind <= rpfa_pkg::t_kind'(i_kind);
                        r_chk  <= chk;
                        if (rpfa_pkg::t_kind'(i_kind) == rpfa_pkg::KIND_INIT) begin
                            r_lim_t    <= managed;
                            r_lim_r    <= resv_eff;
                            r_free_cnt <= managed - resv_eff;
                            r_used_cnt <= resv_eff;
                            r_idx      <= '0;
                            r_init     <= 1'b1;
                            r_state    <= S_SWEEP;
                        end else begin
                            r_state <= S_EXEC;
                        end
                    end
                end
                S_SWEEP: begin
                    r_idx <= r_idx + 1'b1;
                    if (sweep_last) begin
                        r_state <= r_init ? S_EXEC : S_IDLE;
                    end
                end
                S_EXEC: begin
                    if (fire) begin
                        r_free_cnt  <= n_free_cnt;
                        r_used_cnt  <= n_used_cnt;
                        r_out_valid <= 1'b1;
                        r_status    <= n_status;
                        r_granted   <= n_granted;
                        r_count     <= n_count;
                        r_free_out  <= rpfa_pkg::FIELD_W'(n_free_cnt);
                        r_used_out  <= rpfa_pkg::FIELD_W'(n_used_cnt);
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_granted_addr = r_granted;
    assign o_count_after  = r_count;
    assign o_free_total   = r_free_out;
    assign o_used_total   = r_used_out;

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_in_stall)
        else $error("second word taken while a request is in flight");

    a_page_budget: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_free_cnt) + 32'(r_used_cnt)) <= 32'(rpfa_pkg::MAX_PAGES))
        else $error("free and used pages exceed the managed store");

    a_result_from_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_EXEC))
        else $error("result loaded outside the write-back cycle");

    a_oom_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == rpfa_pkg::ST_OOM) |-> (o_free_total == '0))
        else $error("out of memory reported with pages on the stack");

    a_reject_no_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == rpfa_pkg::ST_BAD_ADDR
                      || o_status == rpfa_pkg::ST_DBL_FREE
                      || o_status == rpfa_pkg::ST_OOM)) |-> (o_count_after == '0))
        else $error("rejected request reports a count");

endmodule
